// ===== sv/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stereo peak meter with min/max
// waveform decimation.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int ALPHA_W     = 17;
  localparam int FLOOR_W     = 8;
  localparam int DECIM_W     = 16;
  localparam int COL_SLOT_W  = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  localparam int RING_DEPTH_DEFAULT = 512;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd19661;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 8'd1;
  localparam logic [DECIM_W-1:0] DECIM_RESET = 16'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_FLOOR = 2'd1,
    CFG_DECIM = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       active;
    logic                       last_in_block;
  } in_item_t;

  typedef struct packed {
    logic                       column_valid;
    logic signed [SAMPLE_W-1:0] column_min_left;
    logic signed [SAMPLE_W-1:0] column_max_left;
    logic signed [SAMPLE_W-1:0] column_min_right;
    logic signed [SAMPLE_W-1:0] column_max_right;
    logic [COL_SLOT_W-1:0]      column_slot;
    logic                       level_valid;
    logic [SAMPLE_W-1:0]        level_left;
    logic [SAMPLE_W-1:0]        level_right;
  } out_item_t;

  // What one channel lane reports for the current transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] col_min;
    logic signed [SAMPLE_W-1:0] col_max;
    logic [SAMPLE_W-1:0]        level;
  } lane_res_t;

endpackage

// ===== sv/spm_lane.sv =====
// ----------------------------------------------------------------------------
// spm_lane
// One channel: block peak, running min/max and smoothed level.
// ----------------------------------------------------------------------------
module spm_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 act,
  input  logic                                 last,
  input  logic                                 column,
  input  logic signed [spm_pkg::SAMPLE_W-1:0]  sample,
  input  logic [spm_pkg::ALPHA_W-1:0]          alpha,
  input  logic [spm_pkg::FLOOR_W-1:0]          floor_lsb,
  output spm_pkg::lane_res_t                   res
);

  localparam int W   = spm_pkg::SAMPLE_W;
  localparam int DW  = W + 1;
  localparam int PW  = spm_pkg::ALPHA_W + 1 + DW;
  localparam int FRAC = 16;

  logic [W-1:0]        peak, peak_next, mag, peak_upd;
  logic signed [W-1:0] run_min, run_max, min_upd, max_upd;
  logic [W-1:0]        level, level_next, smooth_r;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod, sum;

  always_comb begin
    mag      = sample[W-1] ? (~sample + 1'b1) : sample;
    peak_upd = (mag > peak) ? mag : peak;
    min_upd  = (sample < run_min) ? sample : run_min;
    max_upd  = (sample > run_max) ? sample : run_max;

    // level + alpha*(peak - level), with the level scaled up by 2^16 and rounded half up
    diff = $signed({1'b0, peak_upd}) - $signed({1'b0, level});
    prod = $signed({1'b0, alpha}) * diff;
    sum  = $signed({{(PW-W-FRAC){1'b0}}, level, {FRAC{1'b0}}}) + prod
         + $signed(PW'(1 << (FRAC-1)));
    smooth_r = sum[W+FRAC-1:FRAC];

    peak_next  = act ? peak_upd : peak;
    level_next = level;
    if (last) begin
      peak_next = '0;
      if (act) begin
        level_next = (smooth_r < {{(W-spm_pkg::FLOOR_W){1'b0}}, floor_lsb}) ? '0 : smooth_r;
      end else begin
        level_next = '0;
      end
    end

    res.col_min = min_upd;
    res.col_max = max_upd;
    res.level   = level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      run_min <= '0;
      run_max <= '0;
      level   <= '0;
    end else if (en) begin
      peak  <= peak_next;
      level <= level_next;
      if (act) begin
        // restart the column at the current sample
        run_min <= column ? sample : min_upd;
        run_max <= column ? sample : max_upd;
      end
    end
  end

endmodule

// ===== sv/spm_out_buf.sv =====
// ----------------------------------------------------------------------------
// spm_out_buf
// Merge lane results into one result item; output register plus skid.
// ----------------------------------------------------------------------------
module spm_out_buf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          column,
  input  logic                          last,
  input  logic [spm_pkg::COL_SLOT_W-1:0] slot,
  input  spm_pkg::lane_res_t            left_res,
  input  spm_pkg::lane_res_t            right_res,
  output logic                          full,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spm_pkg::out_item_t            out_data
);

  spm_pkg::out_item_t merged, main_item, skid_item;
  logic main_valid, skid_valid, take;

  always_comb begin
    merged                  = '0;
    merged.column_valid     = column;
    if (column) begin
      merged.column_min_left  = left_res.col_min;
      merged.column_max_left  = left_res.col_max;
      merged.column_min_right = right_res.col_min;
      merged.column_max_right = right_res.col_max;
      merged.column_slot      = slot;
    end
    merged.level_valid      = last;
    merged.level_left       = left_res.level;
    merged.level_right      = right_res.level;
  end

  assign take = main_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      main_item <= skid_item;
    end else if ((take || !main_valid) && push) begin
      main_item <= merged;
    end
    if (main_valid && !take && push) begin
      skid_item <= merged;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_item;

endmodule

// ===== sv/stereo_peak_meter_minmax_decimator.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_meter_minmax_decimator
// Stereo block peak meter with smoothed levels and min/max waveform columns.
// ----------------------------------------------------------------------------
// One stereo sample is accepted every clock cycle while in_stall is low.
// Left and right run in two identical lanes; each lane updates its peak,
// min/max and smoothed level in the same cycle the sample is taken, with
// one 18x25 multiply for the smoothing step. Results (a column, a level
// update, or both) land in an output register with a one-entry skid behind
// it, so input stalls only once two results are waiting downstream.
// Samples that cause neither a column nor a block end produce no result.
// ----------------------------------------------------------------------------
module stereo_peak_meter_minmax_decimator #(
  parameter int RING_DEPTH = spm_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spm_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spm_pkg::out_item_t              out_data,
  input  logic                            cfg_write,
  input  logic [spm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DW     = spm_pkg::DECIM_W;

  logic [spm_pkg::ALPHA_W-1:0] smoothing_alpha, alpha_eff;
  logic [spm_pkg::FLOOR_W-1:0] level_floor;
  logic [DW-1:0]               decimation_factor;

  logic [DW-1:0]     decimation_count, decimation_count_next;
  logic [DW:0]       count_inc;
  logic [SLOT_W-1:0] slot_pointer, slot_pointer_next;
  logic [SLOT_W+spm_pkg::COL_SLOT_W-1:0] slot_ext;

  logic accept, act, last, column, push;
  spm_pkg::lane_res_t left_res, right_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_alpha   <= spm_pkg::ALPHA_RESET;
      level_floor       <= spm_pkg::FLOOR_RESET;
      decimation_factor <= spm_pkg::DECIM_RESET;
    end else if (cfg_write) begin
      unique case (spm_pkg::cfg_reg_t'(cfg_index))
        spm_pkg::CFG_ALPHA: smoothing_alpha   <= cfg_data;
        spm_pkg::CFG_FLOOR: level_floor       <= cfg_data[spm_pkg::FLOOR_W-1:0];
        spm_pkg::CFG_DECIM: decimation_factor <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_eff = (smoothing_alpha > spm_pkg::ALPHA_ONE) ? spm_pkg::ALPHA_ONE
                                                            : smoothing_alpha;

  assign accept = in_valid & ~in_stall;
  assign act    = in_data.active;
  assign last   = in_data.last_in_block;

  always_comb begin
    count_inc = {1'b0, decimation_count} + 1'b1;
    column    = act & (count_inc >= {1'b0, decimation_factor});
    decimation_count_next = decimation_count;
    slot_pointer_next     = slot_pointer;
    if (act) begin
      decimation_count_next = column ? '0 : count_inc[DW-1:0];
    end
    if (column) begin
      slot_pointer_next = (slot_pointer == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                     : slot_pointer + 1'b1;
    end
    slot_ext = (SLOT_W + spm_pkg::COL_SLOT_W)'(slot_pointer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_count <= '0;
      slot_pointer     <= '0;
    end else if (accept) begin
      decimation_count <= decimation_count_next;
      slot_pointer     <= slot_pointer_next;
    end
  end

  spm_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .act       (act),
    .last      (last),
    .column    (column),
    .sample    (in_data.left_sample),
    .alpha     (alpha_eff),
    .floor_lsb (level_floor),
    .res       (left_res)
  );

  spm_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .act       (act),
    .last      (last),
    .column    (column),
    .sample    (in_data.right_sample),
    .alpha     (alpha_eff),
    .floor_lsb (level_floor),
    .res       (right_res)
  );

  // a transaction yields a result on a column or a block end
  assign push = accept & (column | last);

  spm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .column    (column),
    .last      (last),
    .slot      (slot_ext[spm_pkg::COL_SLOT_W-1:0]),
    .left_res  (left_res),
    .right_res (right_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/stereo_peak_meter_minmax_decimator_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_peak_meter_minmax_decimator_tb
// Drives stereo sample blocks through the peak meter under several register
// settings, with random gaps and output stalls, and checks every column and
// level result against a cycle-free model of the meter held in a scoreboard.
// ----------------------------------------------------------------------------
module stereo_peak_meter_minmax_decimator_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // Model of the meter: register copies, per-channel tracking state and the
  // queue of results still owed by the block.
  class level_column_scoreboard;
    logic [spm_pkg::ALPHA_W-1:0]         alpha;
    logic [spm_pkg::FLOOR_W-1:0]         floor_lsb;
    logic [spm_pkg::DECIM_W-1:0]         decim;
    logic [spm_pkg::SAMPLE_W-1:0]        peak_l, peak_r;
    logic signed [spm_pkg::SAMPLE_W-1:0] min_l, max_l, min_r, max_r;
    logic [spm_pkg::DECIM_W-1:0]         count;
    logic [spm_pkg::COL_SLOT_W-1:0]      slot;
    logic [spm_pkg::SAMPLE_W-1:0]        level_l, level_r;
    spm_pkg::out_item_t                  pending_results[$];
    int                                  errors;

    function new();
      alpha     = spm_pkg::ALPHA_RESET;
      floor_lsb = spm_pkg::FLOOR_RESET;
      decim     = spm_pkg::DECIM_RESET;
      peak_l    = '0;
      peak_r    = '0;
      min_l     = '0;
      max_l     = '0;
      min_r     = '0;
      max_r     = '0;
      count     = '0;
      slot      = '0;
      level_l   = '0;
      level_r   = '0;
      errors    = 0;
    endfunction

    function void set_reg(spm_pkg::cfg_reg_t idx, logic [spm_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        spm_pkg::CFG_ALPHA: alpha = value[spm_pkg::ALPHA_W-1:0];
        spm_pkg::CFG_FLOOR: floor_lsb = value[spm_pkg::FLOOR_W-1:0];
        spm_pkg::CFG_DECIM: decim = value[spm_pkg::DECIM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [spm_pkg::SAMPLE_W-1:0] magnitude(
        logic signed [spm_pkg::SAMPLE_W-1:0] x);
      logic signed [spm_pkg::SAMPLE_W:0] w;
      w = x;
      if (w < 0) w = -w;
      return w[spm_pkg::SAMPLE_W-1:0];
    endfunction

    // Blend the block peak into the level, round half up, zero below floor
    function logic [spm_pkg::SAMPLE_W-1:0] smooth(logic [spm_pkg::SAMPLE_W-1:0] peak,
                                                  logic [spm_pkg::SAMPLE_W-1:0] level);
      logic [63:0] a, sum, r;
      a = (alpha > spm_pkg::ALPHA_ONE) ? 64'd65536 : 64'(alpha);
      sum = a * 64'(peak) + (64'd65536 - a) * 64'(level);
      r = (sum + 64'd32768) >> 16;
      if (r < 64'(floor_lsb)) r = '0;
      return r[spm_pkg::SAMPLE_W-1:0];
    endfunction

    function void owe_result(spm_pkg::out_item_t res);
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void note_sample(spm_pkg::in_item_t s);
      spm_pkg::out_item_t                  res;
      logic signed [spm_pkg::SAMPLE_W-1:0] l, r;
      logic [spm_pkg::DECIM_W:0]           next_count;
      bit                                  col;
      l = s.left_sample;
      r = s.right_sample;
      res = '0;
      col = 1'b0;
      if (s.active) begin
        if (magnitude(l) > peak_l) peak_l = magnitude(l);
        if (magnitude(r) > peak_r) peak_r = magnitude(r);
        if (l < min_l) min_l = l;
        if (l > max_l) max_l = l;
        if (r < min_r) min_r = r;
        if (r > max_r) max_r = r;
        next_count = {1'b0, count} + 1'b1;
        if (next_count >= {1'b0, decim}) begin
          col = 1'b1;
          res.column_valid     = 1'b1;
          res.column_min_left  = min_l;
          res.column_max_left  = max_l;
          res.column_min_right = min_r;
          res.column_max_right = max_r;
          res.column_slot      = slot;
          slot  = slot + 1'b1;
          count = '0;
          min_l = l;
          max_l = l;
          min_r = r;
          max_r = r;
        end else begin
          count = next_count[spm_pkg::DECIM_W-1:0];
        end
      end
      if (s.last_in_block) begin
        if (s.active) begin
          level_l = smooth(peak_l, level_l);
          level_r = smooth(peak_r, level_r);
        end else begin
          level_l = '0;
          level_r = '0;
        end
        peak_l = '0;
        peak_r = '0;
      end
      if (col || s.last_in_block) begin
        res.level_valid = s.last_in_block;
        res.level_left  = level_l;
        res.level_right = level_r;
        owe_result(res);
      end
    endfunction

    function void match_field(string name, logic [spm_pkg::SAMPLE_W-1:0] want,
                              logic [spm_pkg::SAMPLE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(spm_pkg::out_item_t got);
      spm_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      match_field("column_valid", 24'(want.column_valid), 24'(got.column_valid));
      match_field("column_min_left", want.column_min_left, got.column_min_left);
      match_field("column_max_left", want.column_max_left, got.column_max_left);
      match_field("column_min_right", want.column_min_right, got.column_min_right);
      match_field("column_max_right", want.column_max_right, got.column_max_right);
      match_field("column_slot", 24'(want.column_slot), 24'(got.column_slot));
      match_field("level_valid", 24'(want.level_valid), 24'(got.level_valid));
      match_field("level_left", want.level_left, got.level_left);
      match_field("level_right", want.level_right, got.level_right);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  spm_pkg::in_item_t               in_data;
  logic                            out_valid;
  logic                            out_stall;
  spm_pkg::out_item_t              out_data;
  logic                            cfg_write;
  logic [spm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [spm_pkg::CFG_DATA_W-1:0]  cfg_data;

  level_column_scoreboard meter;
  bit                     steady_flow;

  stereo_peak_meter_minmax_decimator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int next_gap();
    if (steady_flow || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic signed [spm_pkg::SAMPLE_W-1:0] random_sample();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 19))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3: return '1;
      4, 5, 6, 7, 8, 9, 10: return 24'($urandom_range(0, 600) - 300);
      default: return w[spm_pkg::SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic spm_pkg::in_item_t make_sample(
      logic signed [spm_pkg::SAMPLE_W-1:0] l,
      logic signed [spm_pkg::SAMPLE_W-1:0] r,
      bit act, bit last);
    spm_pkg::in_item_t s;
    s.left_sample   = l;
    s.right_sample  = r;
    s.active        = act;
    s.last_in_block = last;
    return s;
  endfunction

  // Present one sample; return at the falling edge after it was taken
  task automatic send_sample(input spm_pkg::in_item_t s);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off input until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (meter.pending_results.size() != 0);
  endtask

  task automatic write_reg(input spm_pkg::cfg_reg_t idx,
                           input logic [spm_pkg::CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    meter.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [spm_pkg::CFG_DATA_W-1:0] alpha,
                              input logic [spm_pkg::CFG_DATA_W-1:0] floor_lsb,
                              input logic [spm_pkg::CFG_DATA_W-1:0] decim);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(spm_pkg::CFG_ALPHA, alpha);
    write_reg(spm_pkg::CFG_FLOOR, floor_lsb);
    write_reg(spm_pkg::CFG_DECIM, decim);
    cfg_write <= 1'b0;
  endtask

  // Mostly well-formed blocks ending in a block mark; some inactive or
  // ragged blocks mixed in. Ignored samples do not count toward n_items.
  task automatic stream_blocks(input int n_items);
    int counted, len, mode;
    bit act, last, paused;
    counted = 0;
    paused = 1'b0;
    while (counted < n_items) begin
      len = $urandom_range(1, 12);
      mode = $urandom_range(0, 19);
      for (int i = 0; i < len; i++) begin
        if (mode < 16) act = 1'b1;
        else if (mode < 18) act = 1'b0;
        else act = 1'($urandom_range(0, 1));
        if (i == len - 1) last = (mode != 19);
        else last = ($urandom_range(0, 49) == 0);
        send_sample(make_sample(random_sample(), random_sample(), act, last));
        if (act || last) counted++;
      end
      if (!paused && counted >= n_items / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end
  endtask

  task automatic run_phase(input logic [spm_pkg::CFG_DATA_W-1:0] alpha,
                           input logic [spm_pkg::CFG_DATA_W-1:0] floor_lsb,
                           input logic [spm_pkg::CFG_DATA_W-1:0] decim,
                           input int n_items, input bit steady);
    program_regs(alpha, floor_lsb, decim);
    steady_flow = steady;
    stream_blocks(n_items);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) meter.check_result(out_data);
      if (in_valid && !in_stall) meter.note_sample(in_data);
    end
  end

  // Receiving side: random stall ahead of each result
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = next_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    meter = new();
    steady_flow = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = spm_pkg::CFG_ALPHA;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values: level update only, no column yet
    send_sample(make_sample(24'sd1000, -24'sd2000, 1'b1, 1'b1));
    send_sample(make_sample(24'sd5, 24'sd5, 1'b0, 1'b0));

    // Alpha above one, top floor, column on every active sample
    program_regs(17'h1FFFF, 17'd255, 17'd0);
    send_sample(make_sample(24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0));
    send_sample(make_sample(24'sh800000, 24'sh7FFFFF, 1'b1, 1'b1));
    send_sample(make_sample(24'sd100, -24'sd3, 1'b1, 1'b1));
    send_sample(make_sample(24'sd7, 24'sd7, 1'b0, 1'b0));
    send_sample(make_sample(24'sd7, 24'sd7, 1'b0, 1'b1));

    // Half weight: a peak of one rounds up to one
    program_regs(17'd32768, 17'd0, 17'd3);
    send_sample(make_sample(24'sd1, -24'sd1, 1'b1, 1'b1));
    send_sample(make_sample(-24'sd5, 24'sd9, 1'b1, 1'b0));
    send_sample(make_sample(24'sd0, 24'sd0, 1'b0, 1'b0));
    send_sample(make_sample(24'sd3, -24'sd2, 1'b1, 1'b0));
    send_sample(make_sample(24'sh800000, 24'sh800000, 1'b1, 1'b1));

    // Build up a count, then lower the factor beneath it
    program_regs(17'd0, 17'd0, 17'd65535);
    repeat (5) send_sample(make_sample(random_sample(), random_sample(), 1'b1, 1'b0));
    program_regs(17'd0, 17'd0, 17'd2);
    send_sample(make_sample(24'sd42, -24'sd42, 1'b1, 1'b0));
    send_sample(make_sample(24'sd0, 24'sd0, 1'b1, 1'b1));

    run_phase(17'd65536, 17'd0, 17'd1, 130, 1'b1);
    run_phase(17'd0, 17'd255, 17'd4, 70, 1'b0);
    run_phase(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 255)),
              17'($urandom_range(1, 3)), 70, 1'b0);
    run_phase(17'h1FFFF, 17'd1, 17'd0, 130, 1'b0);
    run_phase(17'(spm_pkg::ALPHA_RESET), 17'($urandom_range(0, 20)), 17'd65535, 40, 1'b0);
    run_phase(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 255)),
              17'($urandom_range(2, 9)), 70, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (meter.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
